// ----- src/packed_genome_motif_scanner_macros.svh -----
// Assertion macros shared by the packed genome motif scanner checkers.
`ifndef PACKED_GENOME_MOTIF_SCANNER_MACROS_SVH
`define PACKED_GENOME_MOTIF_SCANNER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define PGMS_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PGMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset.
`define PGMS_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ----- src/pgms_pkg.sv -----
// Package: shared constants, codes and types of the packed genome motif scanner.
`default_nettype none

package pgms_pkg;

   // genome word and input field widths
   localparam int WORD_BITS = 32;
   localparam int OFF_W     = $clog2(WORD_BITS);
   localparam int POS_W     = 15;
   localparam int WIDX_W    = 10;
   localparam int WSEL_W    = POS_W - OFF_W;
   localparam int SPLIT_W   = WSEL_W / 2;

   // default sizes
   localparam int DEF_GENOME_WORDS = 1024;
   localparam int DEF_PROMOTER_LEN = 22;

   // configuration registers
   localparam int PROMO_REG_W = 22;
   localparam int SD_REG_W    = 13;
   localparam int STOP_REG_W  = 3;
   localparam int CSR_DATA_W  = PROMO_REG_W;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] REG_PROMOTER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHINE_DAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STOP      = 2'd2;

   localparam logic [PROMO_REG_W-1:0] PROMO_RESET = '0;
   localparam logic [SD_REG_W-1:0]    SD_RESET    = '0;
   localparam logic [STOP_REG_W-1:0]  STOP_RESET  = 3'd1;

   // item operations
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLIP  = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   // motif geometry
   localparam int TERM_SIZE    = 4;
   localparam int TERM_OFFSET  = 10;
   localparam int SD_CHECKED   = 9;
   localparam int SD_FIRST_RUN = 6;
   localparam int SD_GAP       = 4;
   localparam int CODON_BITS   = 3;

   // result widths
   localparam int PD_W   = 5;
   localparam int TD_W   = 3;

   typedef struct packed {
      logic [PD_W-1:0]       promoter_distance;
      logic [TD_W-1:0]       terminator_distance;
      logic                  shine_dal_match;
      logic                  stop_match;
      logic [CODON_BITS-1:0] codon_value;
   } score_type;

endpackage

`default_nettype wire

// ----- src/pgms_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module pgms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]              rd_data_a,
   output logic [WIDTH-1:0]              rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ----- src/pgms_score.sv -----
// Motif scoring of the bit window that starts inside a pair of adjacent genome words.
`default_nettype none

module pgms_score #(
   parameter int PROMOTER_LEN = pgms_pkg::DEF_PROMOTER_LEN
) (
   input  wire logic [pgms_pkg::WORD_BITS-1:0]   word_first,
   input  wire logic [pgms_pkg::WORD_BITS-1:0]   word_next,
   input  wire logic [pgms_pkg::OFF_W-1:0]       bit_off,
   input  wire logic [pgms_pkg::PROMO_REG_W-1:0] promoter_pattern,
   input  wire logic [pgms_pkg::SD_REG_W-1:0]    shine_dal_pattern,
   input  wire logic [pgms_pkg::STOP_REG_W-1:0]  stop_pattern,
   output pgms_pkg::score_type                   score
);

   localparam int WB = pgms_pkg::WORD_BITS;
   localparam int CNT_W = $clog2(WB + 1);
   localparam logic [WB-1:0] PMASK = {WB{1'b1}} >> (WB - PROMOTER_LEN);
   localparam logic [CNT_W-1:0] PD_MAX = CNT_W'((1 << pgms_pkg::PD_W) - 1);

   // ones count over nibbles: eight short adds
   function automatic logic [CNT_W-1:0] ones32(input logic [WB-1:0] v);
      logic [CNT_W-1:0] acc;
      acc = '0;
      for (int n = 0; n < WB / 4; n++) begin
         acc = acc + CNT_W'(v[4*n]) + CNT_W'(v[4*n+1])
                   + CNT_W'(v[4*n+2]) + CNT_W'(v[4*n+3]);
      end
      return acc;
   endfunction

   logic [2*WB-1:0]                   pair;
   logic [WB-1:0]                     win;
   logic [WB-1:0]                     pdiff;
   logic [CNT_W-1:0]                  pcount;
   logic [pgms_pkg::TERM_SIZE-1:0]    stem;
   logic [pgms_pkg::TERM_SIZE-1:0]    loop_bits;
   logic [pgms_pkg::TD_W-1:0]         tcount;
   logic                              sd_miss;
   logic [pgms_pkg::CODON_BITS-1:0]   codon;

   // window: bit at pos lands in the msb
   assign pair = {word_first, word_next} << bit_off;
   assign win  = pair[2*WB-1 -: WB];

   // promoter Hamming distance, saturated
   assign pdiff  = ((win >> (WB - PROMOTER_LEN)) ^ WB'(promoter_pattern)) & PMASK;
   assign pcount = ones32(pdiff);

   // stem against reversed loop side, and ribosome site
   always_comb begin
      tcount  = '0;
      sd_miss = 1'b0;
      for (int i = 0; i < pgms_pkg::TERM_SIZE; i++) begin
         stem[pgms_pkg::TERM_SIZE-1-i] = win[WB-1-i];
         loop_bits[i] = win[WB-1-(pgms_pkg::TERM_OFFSET - pgms_pkg::TERM_SIZE + 1 + i)];
      end
      for (int i = 0; i < pgms_pkg::TERM_SIZE; i++) begin
         tcount = tcount + pgms_pkg::TD_W'(stem[i] ^ loop_bits[i]);
      end
      for (int i = 0; i < pgms_pkg::SD_CHECKED; i++) begin
         if (win[WB-1-((i >= pgms_pkg::SD_FIRST_RUN) ? i + pgms_pkg::SD_GAP : i)]
             != shine_dal_pattern[pgms_pkg::SD_REG_W-1-i]) begin
            sd_miss = 1'b1;
         end
      end
   end

   assign codon = win[WB-1 -: pgms_pkg::CODON_BITS];

   assign score.promoter_distance   = (pcount > PD_MAX) ? pgms_pkg::PD_W'(PD_MAX)
                                                        : pgms_pkg::PD_W'(pcount);
   assign score.terminator_distance = tcount;
   assign score.shine_dal_match     = !sd_miss;
   assign score.stop_match          = (codon == stop_pattern);
   assign score.codon_value         = codon;

endmodule

`default_nettype wire

// ----- src/packed_genome_motif_scanner.sv -----
// Top level: packed genome store with bit updates and motif queries.
//
// Usage: items enter on req_* (valid/ready). OP_LOAD stores req_word_data at
// req_word_index (ignored past the genome end), OP_WRITE and OP_FLIP change one
// bit at req_pos, OP_QUERY scores the motifs at req_pos and returns one item
// on rsp_* (valid/ready). Bit positions wrap at the genome end.
// Timing: a load is written at the accepting edge; a write or flip reads the word,
// then writes it back through the single write port of the genome RAM. A query's
// result passes the RAM read register (at the accepting edge), then the output
// register, and back-to-back queries run at 1 per cycle while the output is free,
// set by the two registered read ports of the genome RAM.
// csr_write_en writes a pattern register at once; write only while idle.
// Reset: control and pattern registers go to their reset values, rsp_valid
// drops. Genome words hold nothing defined until loaded; no clearing pass.
// Stall: a result waits in the output register while rsp_ready is low; one
// more query may be read meanwhile, then req_ready stays low until the
// receiver takes the waiting item.
`default_nettype none

module packed_genome_motif_scanner #(
   parameter int GENOME_WORDS = pgms_pkg::DEF_GENOME_WORDS,
   parameter int PROMOTER_LEN = pgms_pkg::DEF_PROMOTER_LEN
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [pgms_pkg::OP_W-1:0]         req_op,
   input  wire logic [pgms_pkg::POS_W-1:0]        req_pos,
   input  wire logic                              req_bit_value,
   input  wire logic [pgms_pkg::WIDX_W-1:0]       req_word_index,
   input  wire logic [pgms_pkg::WORD_BITS-1:0]    req_word_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [pgms_pkg::PD_W-1:0]              rsp_promoter_distance,
   output logic [pgms_pkg::TD_W-1:0]              rsp_terminator_distance,
   output logic                                   rsp_shine_dal_match,
   output logic                                   rsp_stop_match,
   output logic [pgms_pkg::CODON_BITS-1:0]        rsp_codon_value,
   input  wire logic                              csr_write_en,
   input  wire logic [pgms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pgms_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(GENOME_WORDS);
   localparam int WB = pgms_pkg::WORD_BITS;
   localparam int SW = pgms_pkg::SPLIT_W;
   localparam int HW = pgms_pkg::WSEL_W - SW;

   // state codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RMW  = 2'd1;
   localparam logic [1:0] ST_QRY  = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [AW-1:0]                      rmw_addr_ff, rmw_addr_in;
   logic [pgms_pkg::OFF_W-1:0]         off_ff, off_in;
   logic                               flip_ff, flip_in;
   logic                               bit_ff, bit_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   pgms_pkg::score_type                rsp_ff, rsp_in;
   logic [pgms_pkg::PROMO_REG_W-1:0]   promo_ff, promo_in;
   logic [pgms_pkg::SD_REG_W-1:0]      sd_ff, sd_in;
   logic [pgms_pkg::STOP_REG_W-1:0]    stop_ff, stop_in;

   logic                               accept;
   logic                               out_free;
   logic                               rsp_load;
   logic [pgms_pkg::WSEL_W-1:0]        wsel;
   logic [AW-1:0]                      hi_mod [2**HW];
   logic [AW-1:0]                      lo_mod [2**SW];
   logic [AW:0]                        mod_sum;
   logic [AW-1:0]                      addr_first;
   logic [AW-1:0]                      addr_next;
   logic                               widx_ok;
   logic                               ram_we;
   logic [AW-1:0]                      ram_waddr;
   logic [WB-1:0]                      ram_wdata;
   logic                               ram_re;
   logic [WB-1:0]                      rd_first;
   logic [WB-1:0]                      rd_next;
   logic [WB-1:0]                      bit_mask;
   pgms_pkg::score_type                score;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && ((state_ff == ST_IDLE) || (state_ff == ST_QRY && out_free));
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_QRY) && out_free;

   // word address modulo genome length: two residue tables and one fold
   assign wsel = req_pos[pgms_pkg::POS_W-1 -: pgms_pkg::WSEL_W];
   for (genvar g = 0; g < 2**HW; g++) begin : g_hi_mod
      localparam int unsigned HI_V = (g * (2**SW)) % GENOME_WORDS;
      assign hi_mod[g] = AW'(HI_V);
   end
   for (genvar g = 0; g < 2**SW; g++) begin : g_lo_mod
      localparam int unsigned LO_V = g % GENOME_WORDS;
      assign lo_mod[g] = AW'(LO_V);
   end
   assign mod_sum    = {1'b0, hi_mod[wsel[pgms_pkg::WSEL_W-1 -: HW]]}
                     + {1'b0, lo_mod[wsel[SW-1:0]]};
   assign addr_first = (mod_sum >= (AW+1)'(GENOME_WORDS))
                     ? AW'(mod_sum - (AW+1)'(GENOME_WORDS)) : AW'(mod_sum);
   assign addr_next  = (addr_first == AW'(GENOME_WORDS - 1)) ? '0 : addr_first + AW'(1);

   assign widx_ok = (32'(req_word_index) < 32'(GENOME_WORDS));

   // genome RAM ports: load at accept, bit update on write back
   assign bit_mask  = {1'b1, {(WB-1){1'b0}}} >> off_ff;
   assign ram_re    = accept && (req_op != pgms_pkg::OP_LOAD);
   assign ram_we    = (state_ff == ST_RMW) || (accept && req_op == pgms_pkg::OP_LOAD && widx_ok);
   assign ram_waddr = (state_ff == ST_RMW) ? rmw_addr_ff : AW'(req_word_index);

   always_comb begin
      if (state_ff != ST_RMW) begin
         ram_wdata = req_word_data;
      end else if (flip_ff) begin
         ram_wdata = rd_first ^ bit_mask;
      end else if (bit_ff) begin
         ram_wdata = rd_first | bit_mask;
      end else begin
         ram_wdata = rd_first & ~bit_mask;
      end
   end

   pgms_ram #(
      .WIDTH (WB),
      .DEPTH (GENOME_WORDS)
   ) u_genome_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_en     (ram_re),
      .rd_addr_a (addr_first),
      .rd_addr_b (addr_next),
      .rd_data_a (rd_first),
      .rd_data_b (rd_next)
   );

   pgms_score #(
      .PROMOTER_LEN (PROMOTER_LEN)
   ) u_score (
      .word_first        (rd_first),
      .word_next         (rd_next),
      .bit_off           (off_ff),
      .promoter_pattern  (promo_ff),
      .shine_dal_pattern (sd_ff),
      .stop_pattern      (stop_ff),
      .score             (score)
   );

   // sequencer and per-item context
   always_comb begin
      state_in    = state_ff;
      rmw_addr_in = rmw_addr_ff;
      off_in      = off_ff;
      flip_in     = flip_ff;
      bit_in      = bit_ff;
      case (state_ff)
         ST_RMW: begin
            state_in = ST_IDLE;
         end
         ST_IDLE, ST_QRY: begin
            if (state_ff == ST_QRY && !out_free) begin
               state_in = ST_QRY;
            end else if (accept) begin
               rmw_addr_in = addr_first;
               off_in      = req_pos[pgms_pkg::OFF_W-1:0];
               flip_in     = (req_op == pgms_pkg::OP_FLIP);
               bit_in      = req_bit_value;
               case (req_op)
                  pgms_pkg::OP_QUERY: state_in = ST_QRY;
                  pgms_pkg::OP_WRITE: state_in = ST_RMW;
                  pgms_pkg::OP_FLIP:  state_in = ST_RMW;
                  default:            state_in = ST_IDLE;
               endcase
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = rsp_load ? score : rsp_ff;

   // pattern registers
   always_comb begin
      promo_in = promo_ff;
      sd_in    = sd_ff;
      stop_in  = stop_ff;
      if (csr_write_en) begin
         case (csr_index)
            pgms_pkg::REG_PROMOTER:  promo_in = csr_wdata;
            pgms_pkg::REG_SHINE_DAL: sd_in    = csr_wdata[pgms_pkg::SD_REG_W-1:0];
            pgms_pkg::REG_STOP:      stop_in  = csr_wdata[pgms_pkg::STOP_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         promo_ff     <= pgms_pkg::PROMO_RESET;
         sd_ff        <= pgms_pkg::SD_RESET;
         stop_ff      <= pgms_pkg::STOP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         promo_ff     <= promo_in;
         sd_ff        <= sd_in;
         stop_ff      <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      rmw_addr_ff <= rmw_addr_in;
      off_ff      <= off_in;
      flip_ff     <= flip_in;
      bit_ff      <= bit_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_promoter_distance   = rsp_ff.promoter_distance;
   assign rsp_terminator_distance = rsp_ff.terminator_distance;
   assign rsp_shine_dal_match     = rsp_ff.shine_dal_match;
   assign rsp_stop_match          = rsp_ff.stop_match;
   assign rsp_codon_value         = rsp_ff.codon_value;

endmodule

`default_nettype wire

// ----- src/pgms_checker.sv -----
// Port-level checker of the packed genome motif scanner, bound to the top level.
`default_nettype none
`include "packed_genome_motif_scanner_macros.svh"

module pgms_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [pgms_pkg::OP_W-1:0]         req_op,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [pgms_pkg::PD_W-1:0]         rsp_promoter_distance,
   input wire logic [pgms_pkg::TD_W-1:0]         rsp_terminator_distance,
   input wire logic                              rsp_shine_dal_match,
   input wire logic                              rsp_stop_match,
   input wire logic [pgms_pkg::CODON_BITS-1:0]   rsp_codon_value
);

   logic query_acc;

   assign query_acc = req_valid && req_ready && (req_op == pgms_pkg::OP_QUERY);

   // no result left over after reset
   `PGMS_ASSERT_RESET(a_reset_clears, !rsp_valid, "result valid after reset")

   // a stalled result holds
   `PGMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_promoter_distance) && $stable(rsp_terminator_distance) && $stable(rsp_shine_dal_match) && $stable(rsp_stop_match) && $stable(rsp_codon_value), "stalled result changed")

   // a new result comes only from an earlier query, through the RAM read and output registers
   `PGMS_ASSERT(a_rsp_from_query, $rose(rsp_valid), $past(query_acc, 2), "result without query")

   // a query meeting a free output shows its result, through the RAM read and output registers
   `PGMS_ASSERT_NEXT(a_query_answers, query_acc ##1 !rsp_valid, rsp_valid, "query lost")

endmodule

bind packed_genome_motif_scanner pgms_checker u_pgms_checker (.*);

`default_nettype wire
